// ===== rtl/lzwd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lzwd_pkg
// Shared types and constants of the LZ window decompressor: decode phases,
// the command word passed from the parser to the copy engine, format constants.
// ============================================================================
package lzwd_pkg;

  // History ring: the 12-bit distance field of the stream format fixes its size
  localparam int HISTORY_DEPTH  = 4096;
  localparam int HIST_AW        = $clog2(HISTORY_DEPTH);

  // Command queue between parser and copy engine (power of two)
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  // Match length minus one: up to 17
  localparam int LEN_W          = 5;

  localparam logic [7:0]  END_TOKEN  = 8'hff;
  // Flag shifter: bit 16 is the sentinel of a freshly loaded flag byte;
  // once it reaches bit 8 all eight flag bits are used up.
  localparam logic [16:0] FLAG_EMPTY = 17'h00100;
  localparam logic [16:0] FLAG_MARK  = 17'h10000;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_TOKEN,
    PH_LONG2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [7:0]          lit;
    logic [LEN_W-1:0]    len_m1;
    logic [HIST_AW-1:0]  dist_m1;
  } cmd_t;

endpackage

// ===== rtl/lzwd_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lzwd_front
// Stream parser: takes one compressed byte per cycle unless the queue is full,
// tracks flag bits and token phases, and pushes literal, copy and end commands.
// ============================================================================
module lzwd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_stall,
  input  logic            fifo_full,
  output logic            cmd_push,
  output lzwd_pkg::cmd_t  cmd
);

  lzwd_pkg::phase_t phase_r, phase_nxt;
  logic [16:0]      fs_r, fs_nxt;
  logic [7:0]       th_r, th_nxt;

  logic        accept;
  logic [16:0] fs_sh;
  logic [16:0] tf_fs;
  logic        tf_go;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign fs_sh    = fs_r >> 1;

  // Flag bits as seen by the first token byte: already shifted past the first bit
  assign tf_fs = (phase_r == lzwd_pkg::PH_TOKEN) ? fs_r : fs_sh;
  assign tf_go = accept && ((phase_r == lzwd_pkg::PH_TOKEN) ||
                 ((phase_r == lzwd_pkg::PH_TOP) && !fs_r[8] && !fs_r[0] && !fs_sh[8]));

  always_comb begin
    phase_nxt = phase_r;
    fs_nxt    = fs_r;
    th_nxt    = th_r;
    if (accept) begin
      unique case (phase_r)
        lzwd_pkg::PH_LONG2: begin
          fs_nxt    = fs_sh;
          phase_nxt = lzwd_pkg::PH_TOP;
        end
        lzwd_pkg::PH_TOP: begin
          if (fs_r[8]) begin
            fs_nxt = lzwd_pkg::FLAG_MARK | {9'b0, in_byte};
          end else if (fs_r[0]) begin
            fs_nxt = fs_sh;
          end else if (fs_sh[8]) begin
            // first token bit was the last flag bit: fetch a new flag byte
            fs_nxt    = lzwd_pkg::FLAG_MARK | {9'b0, in_byte};
            phase_nxt = lzwd_pkg::PH_TOKEN;
          end
        end
        default: phase_nxt = lzwd_pkg::PH_TOP;
      endcase
      if (tf_go) begin
        if (tf_fs[0]) begin
          th_nxt    = in_byte;
          fs_nxt    = tf_fs;
          phase_nxt = lzwd_pkg::PH_LONG2;
        end else if (in_byte == lzwd_pkg::END_TOKEN) begin
          th_nxt    = '0;
          fs_nxt    = lzwd_pkg::FLAG_EMPTY;
          phase_nxt = lzwd_pkg::PH_TOP;
        end else begin
          fs_nxt    = tf_fs >> 1;
          phase_nxt = lzwd_pkg::PH_TOP;
        end
      end
    end
  end

  always_comb begin
    cmd_push    = 1'b0;
    cmd.kind    = lzwd_pkg::CMD_LIT;
    cmd.lit     = in_byte;
    cmd.len_m1  = '0;
    cmd.dist_m1 = '0;
    if (accept) begin
      unique case (phase_r)
        lzwd_pkg::PH_LONG2: begin
          cmd_push    = 1'b1;
          cmd.kind    = lzwd_pkg::CMD_COPY;
          cmd.len_m1  = {1'b0, th_r[7:4]} + 5'd2;
          cmd.dist_m1 = {th_r[3:0], in_byte};
        end
        lzwd_pkg::PH_TOP: begin
          if (!fs_r[8] && fs_r[0]) begin
            cmd_push = 1'b1;
          end
        end
        default: cmd_push = 1'b0;
      endcase
      if (tf_go && !tf_fs[0]) begin
        cmd_push = 1'b1;
        if (in_byte == lzwd_pkg::END_TOKEN) begin
          cmd.kind = lzwd_pkg::CMD_END;
        end else begin
          cmd.kind    = lzwd_pkg::CMD_COPY;
          cmd.len_m1  = {3'b0, in_byte[7:6]} + 5'd1;
          cmd.dist_m1 = {6'b0, in_byte[5:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lzwd_pkg::PH_TOP;
      fs_r    <= lzwd_pkg::FLAG_EMPTY;
      th_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      fs_r    <= fs_nxt;
      th_r    <= th_nxt;
    end
  end

endmodule

// ===== rtl/lzwd_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lzwd_cmd_fifo
// Short command queue between parser and copy engine.
// ============================================================================
module lzwd_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lzwd_pkg::cmd_t  din,
  input  logic            pop,
  output lzwd_pkg::cmd_t  dout,
  output logic            not_empty,
  output logic            full
);

  lzwd_pkg::cmd_t                     slot_r [lzwd_pkg::CMD_FIFO_DEPTH];
  logic [lzwd_pkg::CMD_PTR_W-1:0]     wr_ptr_r;
  logic [lzwd_pkg::CMD_PTR_W-1:0]     rd_ptr_r;
  logic [lzwd_pkg::CMD_CNT_W-1:0]     cnt_r;

  assign dout      = slot_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == lzwd_pkg::CMD_CNT_W'(lzwd_pkg::CMD_FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/lzwd_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lzwd_back
// Copy engine: runs queued commands one output byte per cycle unless stalled,
// against the 4096-byte history ring, and drives the registered result port.
// ============================================================================
module lzwd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  lzwd_pkg::cmd_t  cmd,
  input  logic            cmd_avail,
  output logic            cmd_pop,
  output logic            out_res_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_run_last,
  output logic            out_stream_end
);

  localparam int AW = lzwd_pkg::HIST_AW;

  logic [7:0] hist_mem [lzwd_pkg::HISTORY_DEPTH];

  // issue side
  logic [AW-1:0]              rpos_r;
  logic [lzwd_pkg::LEN_W-1:0] k_r;

  // execute stage
  logic                   e_valid_r;
  lzwd_pkg::cmd_kind_t    e_kind_r;
  logic [7:0]             e_lit_r;
  logic [AW-1:0]          e_addr_r;
  logic                   e_last_r;
  logic                   hit_r;
  logic [7:0]             wr_data_r;
  logic [7:0]             mem_q_r;

  // result register
  logic       res_valid_r;
  logic [7:0] res_byte_r;
  logic       res_data_valid_r;
  logic       res_last_r;
  logic       res_end_r;

  logic          out_ready;
  logic          e_fire;
  logic          advance;
  logic          issue;
  logic          is_copy;
  logic          copy_last;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    e_data;

  assign out_ready = !res_valid_r || !out_stall;
  assign e_fire    = e_valid_r && out_ready;
  assign advance   = !e_valid_r || out_ready;
  assign issue     = advance && cmd_avail;
  assign is_copy   = (cmd.kind == lzwd_pkg::CMD_COPY);
  assign copy_last = (k_r == cmd.len_m1);
  assign cmd_pop   = issue && (!is_copy || copy_last);
  assign rd_en     = issue && is_copy;
  // source = position - (dist_m1 + 1), modulo the ring size
  assign rd_addr   = rpos_r + ~cmd.dist_m1;
  assign wr_en     = e_fire && (e_kind_r != lzwd_pkg::CMD_END);

  always_comb begin
    case (e_kind_r)
      lzwd_pkg::CMD_LIT:  e_data = e_lit_r;
      lzwd_pkg::CMD_COPY: e_data = hit_r ? wr_data_r : mem_q_r;
      default:            e_data = 8'h00;
    endcase
  end

  // history ring: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[e_addr_r] <= e_data;
    end
    if (rd_en) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  // bypass the byte written in the same cycle as the read (distance one)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= wr_en && (rd_addr == e_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_data_r <= e_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpos_r    <= '0;
      k_r       <= '0;
      e_valid_r <= 1'b0;
    end else if (issue) begin
      e_valid_r <= 1'b1;
      k_r       <= (is_copy && !copy_last) ? k_r + 1'b1 : '0;
      rpos_r    <= (cmd.kind == lzwd_pkg::CMD_END) ? '0 : rpos_r + 1'b1;
    end else if (advance) begin
      e_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      e_kind_r <= cmd.kind;
      e_lit_r  <= cmd.lit;
      e_addr_r <= rpos_r;
      e_last_r <= !is_copy || copy_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (e_fire) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      res_byte_r       <= e_data;
      res_data_valid_r <= (e_kind_r != lzwd_pkg::CMD_END);
      res_last_r       <= e_last_r;
      res_end_r        <= (e_kind_r == lzwd_pkg::CMD_END);
    end
  end

  assign out_res_valid  = res_valid_r;
  assign out_byte       = res_byte_r;
  assign out_valid      = res_data_valid_r;
  assign out_run_last   = res_last_r;
  assign out_stream_end = res_end_r;

endmodule

// ===== rtl/lz_window_decompressor_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lz_window_decompressor_unit
// LZSS-style decompressor with a 4096-byte history window.
// ============================================================================
// Input channel (in_valid / in_stall / in_byte): one compressed byte per
//   transaction, flag, literal and token bytes mixed as they come.
// Result channel (out_res_valid / out_stall): one decompressed byte per
//   transaction on out_byte with out_valid set; out_run_last marks the last
//   byte caused by one input byte, out_stream_end the single result of the
//   end token (out_valid and out_byte zero there).
// Throughput: the parser takes one input byte per cycle while the queue has
//   room; the copy engine emits one output byte per cycle unless the result
//   stalls, so the history ring's single read and write port sets the pace.
//   Flag bytes and the first byte of a long token produce no result.
// Pipeline: the first result of a byte passes the queue write at the accepting
//   edge, the read/execute stage and the result register.
// Stall: in_stall rises only when the four-entry command queue is full; a
//   stalled result holds the output register while the parser keeps filling
//   the queue.
// Reset: synchronous, active low; clears the parser phase, flag shifter,
//   queue and write position. History contents stay undefined until written.
//   The end token returns the block to that state, keeping the history.
// ============================================================================
module lz_window_decompressor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_res_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_run_last,
  output logic       out_stream_end
);

  // Parser -> queue
  logic            cmd_push;
  lzwd_pkg::cmd_t  cmd_in;
  logic            fifo_full;

  // Queue -> copy engine
  lzwd_pkg::cmd_t  cmd_head;
  logic            cmd_avail;
  logic            cmd_pop;

  // Front: classify each byte and turn tokens into commands
  lzwd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_stall  (in_stall),
    .fifo_full (fifo_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // Decouple parsing from copying so each side can stall on its own
  lzwd_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .din       (cmd_in),
    .pop       (cmd_pop),
    .dout      (cmd_head),
    .not_empty (cmd_avail),
    .full      (fifo_full)
  );

  // Back: expand commands byte by byte through the history ring
  lzwd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd_head),
    .cmd_avail      (cmd_avail),
    .cmd_pop        (cmd_pop),
    .out_res_valid  (out_res_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

endmodule

// ===== sim/lz_window_decompressor_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lz_window_decompressor_unit_tb
// Self-checking bench for the LZ window decompressor. Compressed streams are
// built from literal, short-match, long-match and end symbols while a shadow
// of the written history keeps every match inside bytes already produced.
// A driver feeds them byte by byte, a behavioral decoder predicts every
// decompressed byte at acceptance, and a monitor checks the result channel in
// order. Both sides idle in random bursts.
// ============================================================================
module lz_window_decompressor_unit_tb;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 6;
  localparam int RAND_ITEMS   = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_STEP    = 700;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    SYM_LIT,
    SYM_SHORT,
    SYM_LONG
  } sym_kind_t;

  // One symbol of a stream: its data bytes, the flag bits follow from kind
  typedef struct packed {
    sym_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
  } symbol_t;

  // One compressed byte waiting for the driver; drain holds it back until
  // every outstanding result has come out
  typedef struct packed {
    logic [7:0] data;
    logic       drain;
  } comp_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       stream_end;
  } plain_res_t;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte  = 8'h00;
  logic       out_res_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_run_last;
  logic       out_stream_end;

  // Behavioral decoder state
  lzwd_pkg::phase_t dec_phase;
  logic [16:0] flag_sr;
  logic [7:0]  tok_hi;
  logic [7:0]  hist [lzwd_pkg::HISTORY_DEPTH];
  logic [11:0] wr_pos;
  plain_res_t  plain_q[$];

  // Stream builder state: which history slots the decoder will have written
  bit          gen_written [lzwd_pkg::HISTORY_DEPTH];
  logic [11:0] gen_pos;
  symbol_t     sym_q[$];
  comp_byte_t  comp_q[$];

  int   n_items    = 0;
  int   acc_cnt    = 0;
  int   rx_cnt     = 0;
  int   err_cnt    = 0;
  int   cyc_cnt    = 0;
  int   gap_left   = 0;
  int   burst_left = 0;
  int   hold_left  = 0;
  int   hold_at    = 120;
  logic quiet;

  // No idling in the last eighth of the run
  assign quiet = (acc_cnt * 8 >= n_items * 7);

  lz_window_decompressor_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_res_valid  (out_res_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------
  function automatic void clear_decoder();
    dec_phase = lzwd_pkg::PH_TOP;
    flag_sr   = lzwd_pkg::FLAG_EMPTY;
    tok_hi    = '0;
    wr_pos    = '0;
  endfunction

  // Write one byte into the history ring and queue it as a result
  function automatic void emit_plain(input logic [7:0] b, input logic last);
    hist[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    plain_q.push_back('{data: b, valid: 1'b1, run_last: last, stream_end: 1'b0});
  endfunction

  // Copy byte by byte so that overlapping matches repeat bytes; a distance of
  // the full ring size truncates to zero and reads the slot about to be written
  function automatic void copy_match(input int len, input int back_dist);
    logic [11:0] src;
    for (int i = 0; i < len; i++) begin
      src = wr_pos - 12'(back_dist);
      emit_plain(hist[src], i == len - 1);
    end
  endfunction

  function automatic void decode_token(input logic [7:0] b);
    if (flag_sr[0]) begin
      // Second flag bit set: first byte of a long token
      tok_hi    = b;
      dec_phase = lzwd_pkg::PH_LONG2;
    end else if (b == lzwd_pkg::END_TOKEN) begin
      plain_q.push_back('{data: 8'h00, valid: 1'b0, run_last: 1'b1, stream_end: 1'b1});
      clear_decoder();
    end else begin
      flag_sr   = flag_sr >> 1;
      dec_phase = lzwd_pkg::PH_TOP;
      copy_match(int'(b[7:6]) + 2, int'(b[5:0]) + 1);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    case (dec_phase)
      lzwd_pkg::PH_LONG2: begin
        flag_sr   = flag_sr >> 1;
        dec_phase = lzwd_pkg::PH_TOP;
        copy_match(int'(tok_hi[7:4]) + 3, int'({tok_hi[3:0], b}) + 1);
      end
      lzwd_pkg::PH_TOKEN: begin
        decode_token(b);
      end
      default: begin
        dec_phase = lzwd_pkg::PH_TOP;
        if (flag_sr[8]) begin
          flag_sr = lzwd_pkg::FLAG_MARK | 17'(b);
        end else if (flag_sr[0]) begin
          emit_plain(b, 1'b1);
          flag_sr = flag_sr >> 1;
        end else begin
          flag_sr = flag_sr >> 1;
          // Token starts on the last flag bit: next flag byte comes first
          if (flag_sr[8]) begin
            flag_sr   = lzwd_pkg::FLAG_MARK | 17'(b);
            dec_phase = lzwd_pkg::PH_TOKEN;
          end else begin
            decode_token(b);
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stream builder
  // --------------------------------------------------------------------------
  function automatic void add_literal(input logic [7:0] b);
    sym_q.push_back('{kind: SYM_LIT, b0: b, b1: 8'h00});
    gen_written[gen_pos] = 1'b1;
    gen_pos = gen_pos + 1'b1;
  endfunction

  // Add a match only if every byte it reads is already written (or is
  // written by the copy itself); return whether it was added
  function automatic bit add_match(input bit is_long, input int len, input int back_dist);
    logic [11:0] d_m1;
    d_m1 = 12'(back_dist - 1);
    for (int i = 0; i < len && i < back_dist; i++)
      if (!gen_written[gen_pos + 12'(i) - 12'(back_dist)]) return 1'b0;
    if (is_long)
      sym_q.push_back('{kind: SYM_LONG, b0: {4'(len - 3), d_m1[11:8]}, b1: d_m1[7:0]});
    else
      sym_q.push_back('{kind: SYM_SHORT, b0: {2'(len - 2), d_m1[5:0]}, b1: 8'h00});
    for (int i = 0; i < len; i++) begin
      gen_written[gen_pos] = 1'b1;
      gen_pos = gen_pos + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void add_end();
    sym_q.push_back('{kind: SYM_SHORT, b0: lzwd_pkg::END_TOKEN, b1: 8'h00});
    gen_pos = '0;
  endfunction

  function automatic void push_comp(input logic [7:0] b, inout bit drain);
    comp_q.push_back('{data: b, drain: drain});
    drain = 1'b0;
  endfunction

  // Interleave flag bytes with the symbol bytes; unused flag bits after the
  // end token are random
  function automatic void encode_stream(input bit drain);
    bit         flag_bits[$];
    logic [7:0] fbytes[$];
    logic [7:0] fb;
    int         p;
    bit         hold;
    foreach (sym_q[k]) begin
      if (sym_q[k].kind == SYM_LIT) begin
        flag_bits.push_back(1'b1);
      end else begin
        flag_bits.push_back(1'b0);
        flag_bits.push_back(sym_q[k].kind == SYM_LONG);
      end
    end
    while (flag_bits.size() % 8 != 0) flag_bits.push_back(1'($urandom));
    for (int g = 0; g < flag_bits.size(); g += 8) begin
      for (int j = 0; j < 8; j++) fb[j] = flag_bits[g + j];
      fbytes.push_back(fb);
    end
    p    = 0;
    hold = drain;
    foreach (sym_q[k]) begin
      if (p % 8 == 0) push_comp(fbytes[p / 8], hold);
      p++;
      if (sym_q[k].kind != SYM_LIT) begin
        if (p % 8 == 0) push_comp(fbytes[p / 8], hold);
        p++;
      end
      push_comp(sym_q[k].b0, hold);
      if (sym_q[k].kind == SYM_LONG) push_comp(sym_q[k].b1, hold);
    end
    sym_q.delete();
  endfunction

  function automatic void add_random_symbol();
    int pick;
    int len;
    int back_dist;
    bit is_long;
    bit done;
    pick    = $urandom_range(0, 99);
    is_long = pick >= 65;
    len     = is_long ? $urandom_range(3, 18) : $urandom_range(2, 5);
    done    = 1'b0;
    if (pick >= 35) begin
      for (int t = 0; t < 8 && !done; t++) begin
        if (!is_long) begin
          back_dist = $urandom_range(1, 64);
        end else begin
          case ($urandom_range(0, 2))
            0:       back_dist = $urandom_range(1, 16);
            1:       back_dist = $urandom_range(1, lzwd_pkg::HISTORY_DEPTH);
            default: back_dist = lzwd_pkg::HISTORY_DEPTH - $urandom_range(0, 64);
          endcase
        end
        // Short length 5 at distance 64 would encode the end token
        if (is_long || len != 5 || back_dist != 64)
          done = add_match(is_long, len, back_dist);
      end
      if (!done) done = add_match(is_long, len, 1);
    end
    if (!done) add_literal(8'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: advance to the next byte once the current transaction is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        acc_cnt <= acc_cnt + 1;
        if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 17);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (comp_q.size() != 0 && !(comp_q[0].drain && plain_q.size() != 0)) begin
          in_valid <= 1'b1;
          in_byte  <= comp_q[0].data;
          void'(comp_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random bursts, plus a long hold-off that lets the command
  // queue fill and push back on the input side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      burst_left = 0;
      hold_left  = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!quiet && rx_cnt >= hold_at) begin
      out_stall <= 1'b1;
      hold_left = LONG_HOLD - 1;
      hold_at   = hold_at + HOLD_STEP;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the falling edge, where the values that the next
  // rising edge will take are settled and the decoder is not being updated
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    plain_res_t got;
    plain_res_t want;
    if (rst_n && out_res_valid && !out_stall) begin
      got = '{data: out_byte, valid: out_valid, run_last: out_run_last,
              stream_end: out_stream_end};
      rx_cnt <= rx_cnt + 1;
      if (plain_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result: byte %02h valid %b last %b end %b",
                   $realtime, got.data, got.valid, got.run_last, got.stream_end);
      end else begin
        want = plain_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display({"%0t: result %0d mismatch: expected byte %02h valid %b last %b ",
                      "end %b, got byte %02h valid %b last %b end %b"},
                     $realtime, rx_cnt, want.data, want.valid, want.run_last,
                     want.stream_end, got.data, got.valid, got.run_last, got.stream_end);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("lz_window_decompressor_unit_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    clear_decoder();
    gen_pos = '0;

    // Byte extremes as literals, both match forms at their length extremes,
    // a long token split across two flag bytes, short distance 64, overlaps
    add_literal(8'h00);
    add_literal(8'hff);
    add_literal(8'h5a);
    void'(add_match(1'b0, 2, 1));
    void'(add_match(1'b0, 5, 3));
    void'(add_match(1'b1, 18, 1));
    add_literal(8'ha5);
    void'(add_match(1'b1, 3, 20));
    void'(add_match(1'b0, 3, 32));
    void'(add_match(1'b1, 18, 2));
    void'(add_match(1'b1, 18, 4));
    void'(add_match(1'b0, 4, 64));
    add_end();
    encode_stream(1'b1);

    // After the end token: full-ring distances read bytes kept from before,
    // and 0xff as the first byte of a long token is not an end marker
    void'(add_match(1'b1, 3, lzwd_pkg::HISTORY_DEPTH));
    add_literal(8'h81);
    void'(add_match(1'b1, 18, lzwd_pkg::HISTORY_DEPTH));
    add_end();
    encode_stream(1'b1);

    // Random well-formed streams; some wait for the block to drain first
    n_items = comp_q.size();
    encode_stream(1'b0);
    while (comp_q.size() < n_items + RAND_ITEMS) begin
      for (int s = $urandom_range(1, 40); s > 0; s--) add_random_symbol();
      add_end();
      encode_stream(comp_q.size() == n_items || $urandom_range(0, 19) == 0);
    end
    n_items = comp_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (acc_cnt < n_items) @(posedge clk);
    while (plain_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && plain_q.size() == 0) begin
      $display("lz_window_decompressor_unit_tb passed");
    end else begin
      $display("lz_window_decompressor_unit_tb failed");
    end
    $finish;
  end

endmodule
